[rtl/core/double_ended_priority_queue_top_defines.svh]
// assertion macros for the double ended priority queue checker
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same cycle implication, off while reset is held
`define DEP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dep check failed");

// next cycle implication, off while reset is held
`define DEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dep check failed");

`endif

[rtl/core/dep_pkg.sv]
package dep_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CAPACITY = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT     = 3'd0,
        KIND_PEEK_MIN   = 3'd1,
        KIND_REMOVE_MIN = 3'd2,
        KIND_PEEK_MAX   = 3'd3,
        KIND_REMOVE_MAX = 3'd4,
        KIND_COUNT      = 3'd5,
        KIND_CLEAR      = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_ERROR = 2'd2,
        ST_COUNT = 2'd3
    } t_status;

    // broadcast to every cell
    typedef struct packed {
        logic                     insert;
        logic                     shift_down;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

[rtl/core/dep_cell.sv]
module dep_cell (
    input  logic                             i_clk,
    input  dep_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_live,
    input  logic signed [dep_pkg::DATA_W-1:0] i_prev_val,
    input  logic                             i_prev_lt,
    input  logic signed [dep_pkg::DATA_W-1:0] i_next_val,
    output logic signed [dep_pkg::DATA_W-1:0] o_val,
    output logic                             o_lt
);

    logic signed [dep_pkg::DATA_W-1:0] r_val;
    logic signed [dep_pkg::DATA_W-1:0] n_val;

    // new word belongs at or below this cell
    assign o_lt = !i_live || (i_ctl.value < r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (o_lt) begin
                n_val = i_prev_lt ? i_prev_val : i_ctl.value;
            end
        end else if (i_ctl.shift_down) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[rtl/core/double_ended_priority_queue_top.sv]
// channel   | ports                          | direction | handshake
// command   | i_kind, i_value                | in        | start high, busy low
// result    | o_status, o_data, o_count      | out       | strobe, one cycle
//
// one command per cycle: the sorted cell chain shifts or inserts as each command is taken
// the result appears on the cycle after the command is taken, for one cycle only
// busy stays low; the receiver cannot stall, so nothing waits
// synchronous active-low reset empties the queue; cell contents are not cleared
module double_ended_priority_queue_top #(
    parameter int CAPACITY = dep_pkg::CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dep_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [dep_pkg::DATA_W-1:0] i_value,
    output logic                              strobe,
    output logic [dep_pkg::STATUS_W-1:0]      o_status,
    output logic signed [dep_pkg::DATA_W-1:0] o_data,
    output logic [dep_pkg::COUNT_W-1:0]       o_count
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0]                  r_occ;
    logic [OCC_W-1:0]                  n_occ;
    logic                              r_strobe;
    dep_pkg::t_status                  r_status;
    dep_pkg::t_status                  n_status;
    logic signed [dep_pkg::DATA_W-1:0] r_data;
    logic signed [dep_pkg::DATA_W-1:0] n_data;
    logic [dep_pkg::COUNT_W-1:0]       r_count;

    dep_pkg::t_cell_ctl                ctl;
    dep_pkg::t_kind                    kind;
    logic                              accept;
    logic                              empty;
    logic                              full;
    logic signed [dep_pkg::DATA_W-1:0] max_val;

    logic signed [dep_pkg::DATA_W-1:0] w_val  [CAPACITY];
    logic signed [dep_pkg::DATA_W-1:0] w_mask [CAPACITY];
    logic                              w_lt   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign kind   = dep_pkg::t_kind'(i_kind);
    assign empty  = (r_occ == '0);
    assign full   = (r_occ == OCC_W'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [dep_pkg::DATA_W-1:0] prev_val;
        logic                              prev_lt;
        logic signed [dep_pkg::DATA_W-1:0] next_val;

        if (g == 0) begin : g_first
            assign prev_val = '0;
            assign prev_lt  = 1'b0;
        end else begin : g_mid
            assign prev_val = w_val[g-1];
            assign prev_lt  = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_val = w_val[g];
        end else begin : g_inner
            assign next_val = w_val[g+1];
        end

        // top entry tap for the max read
        assign w_mask[g] = (OCC_W'(g + 1) == r_occ) ? w_val[g] : '0;

        dep_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_live     (OCC_W'(g) < r_occ),
            .i_prev_val (prev_val),
            .i_prev_lt  (prev_lt),
            .i_next_val (next_val),
            .o_val      (w_val[g]),
            .o_lt       (w_lt[g])
        );
    end

    always_comb begin
        max_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            max_val = max_val | w_mask[k];
        end
    end

    always_comb begin
        n_occ          = r_occ;
        n_status       = dep_pkg::ST_ERROR;
        n_data         = '0;
        ctl.insert     = 1'b0;
        ctl.shift_down = 1'b0;
        ctl.value      = i_value;
        case (kind)
            dep_pkg::KIND_INSERT: begin
                if (!full) begin
                    ctl.insert = accept;
                    n_occ      = r_occ + 1'b1;
                    n_status   = dep_pkg::ST_OK;
                end
            end
            dep_pkg::KIND_PEEK_MIN: begin
                if (!empty) begin
                    n_data   = w_val[0];
                    n_status = dep_pkg::ST_VALUE;
                end
            end
            dep_pkg::KIND_REMOVE_MIN: begin
                if (!empty) begin
                    ctl.shift_down = accept;
                    n_data         = w_val[0];
                    n_status       = dep_pkg::ST_VALUE;
                    n_occ          = r_occ - 1'b1;
                end
            end
            dep_pkg::KIND_PEEK_MAX: begin
                if (!empty) begin
                    n_data   = max_val;
                    n_status = dep_pkg::ST_VALUE;
                end
            end
            dep_pkg::KIND_REMOVE_MAX: begin
                if (!empty) begin
                    n_data   = max_val;
                    n_status = dep_pkg::ST_VALUE;
                    n_occ    = r_occ - 1'b1;
                end
            end
            dep_pkg::KIND_COUNT: begin
                n_status = dep_pkg::ST_COUNT;
            end
            dep_pkg::KIND_CLEAR: begin
                n_occ    = '0;
                n_status = dep_pkg::ST_OK;
            end
            default: begin
                n_status = dep_pkg::ST_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_occ   <= n_occ;
                r_count <= dep_pkg::COUNT_W'(n_occ);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign strobe   = r_strobe;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_count  = r_count;

endmodule

[rtl/core/dep_checker.sv]
`include "double_ended_priority_queue_top_defines.svh"

module dep_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [dep_pkg::KIND_W-1:0]        i_kind,
    input logic                              strobe,
    input logic [dep_pkg::STATUS_W-1:0]      o_status,
    input logic signed [dep_pkg::DATA_W-1:0] o_data,
    input logic [dep_pkg::COUNT_W-1:0]       o_count
);

    logic                         cmd_take;
    logic                         cmd_clear;
    logic                         cmd_insert;
    logic                         was_refused;
    logic [dep_pkg::COUNT_W-1:0]  count_up;

    assign cmd_take    = start && !busy;
    assign cmd_clear   = cmd_take && (i_kind == dep_pkg::KIND_CLEAR);
    assign cmd_insert  = cmd_take && (i_kind == dep_pkg::KIND_INSERT);
    assign was_refused = (o_status == dep_pkg::ST_ERROR);
    assign count_up    = o_count + 1'b1;

    // one result word for every command word, in the cycle after it is taken
    `DEP_ASSERT_NEXT(a_one_result, 1'b1, strobe == $past(cmd_take && i_rst_n))

    // data is only non-zero when a value comes back
    `DEP_ASSERT_NOW(a_data_zero, strobe && (o_status != dep_pkg::ST_VALUE), o_data == '0)

    // clear always succeeds and empties the queue
    `DEP_ASSERT_NEXT(a_clear, cmd_clear, (o_status == dep_pkg::ST_OK) && (o_count == '0))

    // a successful insert grows the count by one
    `DEP_ASSERT_NEXT(a_insert_count, cmd_insert, was_refused || (o_count == $past(count_up)))

endmodule

bind double_ended_priority_queue_top dep_checker u_dep_checker (.*);
